// ===== rtl/calda_pkg.sv =====
package calda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DAYS_W  = 16;
    localparam int ALU_W   = (DAYS_W > YEAR_W) ? DAYS_W : YEAR_W;

    localparam int K_W        = 3;
    localparam int REDUCE_TOP = 5;

    localparam int CYCLE_400 = 400;
    localparam int CENT_100  = 100;
    localparam int CENT_200  = 200;
    localparam int CENT_300  = 300;
    localparam int LAST_MON  = 12;
    localparam int FEB       = 2;
    localparam int FEB_LEAP  = 29;
    localparam int FEB_PLAIN = 28;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [DAYS_W-1:0]  day_count;
    } t_in_word;

    typedef struct packed {
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic           busy;
        logic           load;
        logic           reduce;
        logic           step;
        logic           done;
        logic [K_W-1:0] shift;
    } t_ctrl;

    typedef struct packed {
        logic n_zero;
    } t_stat;

    function automatic logic is_leap(input logic [YEAR_W-1:0] rem);
        logic lp;
        lp = (rem[1:0] == 2'b00) &&
             (rem != YEAR_W'(CENT_100)) &&
             (rem != YEAR_W'(CENT_200)) &&
             (rem != YEAR_W'(CENT_300));
        return lp;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2: begin
                len = leap ? DAY_W'(FEB_LEAP) : DAY_W'(FEB_PLAIN);
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/calda_alu.sv =====
module calda_alu (
    input  logic [calda_pkg::ALU_W-1:0] i_a,
    input  logic [calda_pkg::ALU_W-1:0] i_b,
    output logic [calda_pkg::ALU_W-1:0] o_diff,
    output logic                        o_ge
);

    logic borrow;

    assign {borrow, o_diff} = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge = ~borrow;

endmodule

// ===== rtl/calda_ctrl.sv =====
module calda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  calda_pkg::t_stat i_stat,
    output calda_pkg::t_ctrl o_ctl
);

    calda_pkg::t_state r_state, n_state;
    logic [calda_pkg::K_W-1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= calda_pkg::S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            calda_pkg::S_IDLE: begin
                if (start) begin
                    n_state = calda_pkg::S_REDUCE;
                    n_k     = calda_pkg::K_W'(calda_pkg::REDUCE_TOP);
                end
            end
            calda_pkg::S_REDUCE: begin
                if (r_k == '0) begin
                    n_state = calda_pkg::S_STEP;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            calda_pkg::S_STEP: begin
                if (i_stat.n_zero) begin
                    n_state = calda_pkg::S_DONE;
                end
            end
            calda_pkg::S_DONE: begin
                n_state = calda_pkg::S_IDLE;
            end
            default: begin
                n_state = calda_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl = '0;
        o_ctl.shift = r_k;
        case (r_state)
            calda_pkg::S_IDLE: begin
                o_ctl.load = start;
            end
            calda_pkg::S_REDUCE: begin
                o_ctl.busy   = 1'b1;
                o_ctl.reduce = 1'b1;
            end
            calda_pkg::S_STEP: begin
                o_ctl.busy = 1'b1;
                o_ctl.step = ~i_stat.n_zero;
            end
            calda_pkg::S_DONE: begin
                o_ctl.busy = 1'b1;
                o_ctl.done = 1'b1;
            end
            default: begin
                o_ctl.busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/calendar_date_advance.sv =====
// Channel   Ports                      Handshake
// command   i_cmd (t_in_word)          taken when start is high and busy is low
// result    o_result (t_out_word)      valid for one cycle while o_valid is high
//
// After a word is accepted, the sequencer first reduces the year mod 400 in
// REDUCE, then crosses one month boundary per cycle in STEP through the shared
// subtract/compare unit, with a final step when the count ends inside a month.
// The number of month boundaries crossed is at most about 2160 for the widest
// count. The result strobe follows in DONE, after which the block is idle.
// Reset is synchronous, active low, and returns the sequencer to idle.
// The receiver cannot stall; the result is shown once and busy drops after it.
module calendar_date_advance (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  calda_pkg::t_in_word  i_cmd,
    output logic                 busy,
    output logic                 o_valid,
    output calda_pkg::t_out_word o_result
);

    calda_pkg::t_ctrl ctl;
    calda_pkg::t_stat stat;

    logic [calda_pkg::YEAR_W-1:0]  r_year, n_year;
    logic [calda_pkg::MONTH_W-1:0] r_month, n_month;
    logic [calda_pkg::DAY_W-1:0]   r_day, n_day;
    logic [calda_pkg::DAYS_W-1:0]  r_count, n_count;
    logic [calda_pkg::YEAR_W-1:0]  r_rem, n_rem;

    logic [calda_pkg::DAY_W-1:0] len;
    logic [calda_pkg::DAY_W-1:0] gap;
    logic [calda_pkg::ALU_W-1:0] alu_a, alu_b, alu_diff;
    logic                        alu_ge;

    assign stat.n_zero = (r_count == '0);

    calda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    calda_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff),
        .o_ge   (alu_ge)
    );

    assign len = calda_pkg::month_len(r_month, calda_pkg::is_leap(r_rem));
    assign gap = (r_day < len) ? (len - r_day) : '0;

    always_comb begin
        if (ctl.reduce) begin
            alu_a = calda_pkg::ALU_W'(r_rem);
            alu_b = calda_pkg::ALU_W'(calda_pkg::CYCLE_400) << ctl.shift;
        end else begin
            alu_a = calda_pkg::ALU_W'(r_count);
            alu_b = calda_pkg::ALU_W'(gap) + calda_pkg::ALU_W'(1);
        end
    end

    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_count = r_count;
        n_rem   = r_rem;
        if (ctl.load) begin
            n_year  = i_cmd.start_year;
            n_month = i_cmd.start_month;
            n_day   = i_cmd.start_day;
            n_count = i_cmd.day_count;
            n_rem   = i_cmd.start_year;
        end else if (ctl.reduce) begin
            if (alu_ge) begin
                n_rem = alu_diff[calda_pkg::YEAR_W-1:0];
            end
        end else if (ctl.step) begin
            if (!alu_ge) begin
                n_day   = r_day + r_count[calda_pkg::DAY_W-1:0];
                n_count = '0;
            end else begin
                n_count = alu_diff[calda_pkg::DAYS_W-1:0];
                n_day   = calda_pkg::DAY_W'(1);
                if (r_month < calda_pkg::MONTH_W'(calda_pkg::LAST_MON)) begin
                    n_month = r_month + 1'b1;
                end else begin
                    n_month = calda_pkg::MONTH_W'(1);
                    n_year  = r_year + 1'b1;
                    if (r_year == '1 ||
                        r_rem == calda_pkg::YEAR_W'(calda_pkg::CYCLE_400 - 1)) begin
                        n_rem = '0;
                    end else begin
                        n_rem = r_rem + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_count <= n_count;
        r_rem   <= n_rem;
    end

    assign busy              = ctl.busy;
    assign o_valid           = ctl.done;
    assign o_result.end_year  = r_year;
    assign o_result.end_month = r_month;
    assign o_result.end_day   = r_day;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a busy period");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("block did not return to idle after the result");

    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count == '0))
        else $error("result shown with days left to advance");

endmodule
